// ===== hw/rtl/writ_pkg.sv =====
package writ_pkg;

    localparam int SecW  = 13;
    localparam int RndW  = 7;
    localparam int BeepW = 4;
    localparam int ApbAw = 4;
    localparam int ApbDw = 32;

    localparam logic [SecW-1:0]  SEC_MAX  = '1;
    localparam logic [RndW-1:0]  RND_MAX  = '1;
    localparam logic [SecW-1:0]  WARN_SEC = 13'd3;

    localparam logic [BeepW-1:0] BEEP_NONE   = 4'd0;
    localparam logic [BeepW-1:0] BEEP_WARN   = 4'd1;
    localparam logic [BeepW-1:0] BEEP_PHASE  = 4'd3;
    localparam logic [BeepW-1:0] BEEP_FINISH = 4'd10;

    // register indexes on the APB port (byte address = 4 * index)
    localparam logic [1:0] REG_COUNT_UP_MODE = 2'd0;
    localparam logic [1:0] REG_WORK_SECONDS  = 2'd1;
    localparam logic [1:0] REG_REST_SECONDS  = 2'd2;
    localparam logic [1:0] REG_ROUND_TOTAL   = 2'd3;

    localparam logic [SecW-1:0] WORK_SECONDS_RST = 13'd30;
    localparam logic [SecW-1:0] REST_SECONDS_RST = 13'd10;
    localparam logic [RndW-1:0] ROUND_TOTAL_RST  = 7'd8;

    typedef struct packed {
        logic op;
        logic hold;
    } writ_item_t;

    typedef struct packed {
        logic [SecW-1:0]  seconds_shown;
        logic [RndW-1:0]  round_shown;
        logic             in_work;
        logic             done_res;
        logic [BeepW-1:0] beep_count;
    } writ_result_t;

    typedef struct packed {
        logic            count_up_mode;
        logic [SecW-1:0] work_seconds;
        logic [SecW-1:0] rest_seconds;
        logic [RndW-1:0] round_total;
    } writ_cfg_t;

endpackage

// ===== hw/rtl/writ_cfg.sv =====
module writ_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [writ_pkg::ApbAw-1:0]  paddr,
    input  logic [writ_pkg::ApbDw-1:0]  pwdata,
    output logic [writ_pkg::ApbDw-1:0]  prdata,
    output logic                        pready,
    output writ_pkg::writ_cfg_t         cfg
);
    import writ_pkg::*;

    writ_cfg_t  cfg_reg;
    writ_cfg_t  cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_COUNT_UP_MODE: cfg_next.count_up_mode = pwdata[0];
                REG_WORK_SECONDS:  cfg_next.work_seconds  = pwdata[SecW-1:0];
                REG_REST_SECONDS:  cfg_next.rest_seconds  = pwdata[SecW-1:0];
                REG_ROUND_TOTAL:   cfg_next.round_total   = pwdata[RndW-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count_up_mode <= 1'b0;
            cfg_reg.work_seconds  <= WORK_SECONDS_RST;
            cfg_reg.rest_seconds  <= REST_SECONDS_RST;
            cfg_reg.round_total   <= ROUND_TOTAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COUNT_UP_MODE: prdata = {{(ApbDw-1){1'b0}}, cfg_reg.count_up_mode};
            REG_WORK_SECONDS:  prdata = {{(ApbDw-SecW){1'b0}}, cfg_reg.work_seconds};
            REG_REST_SECONDS:  prdata = {{(ApbDw-SecW){1'b0}}, cfg_reg.rest_seconds};
            REG_ROUND_TOTAL:   prdata = {{(ApbDw-RndW){1'b0}}, cfg_reg.round_total};
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/writ_core.sv =====
module writ_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  writ_pkg::writ_item_t    item,
    input  writ_pkg::writ_cfg_t     cfg,
    output writ_pkg::writ_result_t  result
);
    import writ_pkg::*;

    logic [SecW-1:0]  sec_reg,   sec_next;
    logic [RndW-1:0]  rnd_reg,   rnd_next;
    logic             work_reg,  work_next;
    logic             done_reg,  done_next;
    logic [BeepW-1:0] beep;

    logic [SecW-1:0]  len;
    logic [SecW-1:0]  up_cnt;
    logic [SecW:0]    up_left;
    logic             up_warn;
    logic             up_end;
    logic [SecW-1:0]  dn_cnt;
    logic [RndW-1:0]  rnd_inc;
    logic [RndW-1:0]  rnd_dec;

    assign len     = work_reg ? cfg.work_seconds : cfg.rest_seconds;
    assign up_cnt  = (sec_reg != SEC_MAX) ? sec_reg + 13'd1 : sec_reg;
    assign up_left = {1'b0, len} - {1'b0, up_cnt};
    assign up_end  = (len <= up_cnt);
    assign up_warn = !up_end && (up_left <= {1'b0, WARN_SEC});
    assign dn_cnt  = (sec_reg != '0) ? sec_reg - 13'd1 : sec_reg;
    assign rnd_inc = (rnd_reg != RND_MAX) ? rnd_reg + 7'd1 : rnd_reg;
    assign rnd_dec = (rnd_reg != '0) ? rnd_reg - 7'd1 : rnd_reg;

    always_comb
    begin
        sec_next  = sec_reg;
        rnd_next  = rnd_reg;
        work_next = work_reg;
        done_next = done_reg;
        beep      = BEEP_NONE;
        if (item.op)
        begin
            // load the program
            sec_next  = cfg.count_up_mode ? '0 : cfg.work_seconds;
            rnd_next  = cfg.count_up_mode ? 7'd1 : cfg.round_total;
            work_next = 1'b1;
            done_next = 1'b0;
        end
        else if (!item.hold && !done_reg)
        begin
            if (cfg.count_up_mode)
            begin
                sec_next = up_cnt;
                if (up_warn)
                    beep = BEEP_WARN;
                if (up_end)
                begin
                    sec_next = '0;
                    beep     = BEEP_PHASE;
                    if (work_reg)
                    begin
                        work_next = 1'b0;
                        if (rnd_reg >= cfg.round_total)
                        begin
                            done_next = 1'b1;
                            beep      = BEEP_FINISH;
                        end
                    end
                    else
                    begin
                        work_next = 1'b1;
                        rnd_next  = rnd_inc;
                    end
                end
            end
            else
            begin
                sec_next = dn_cnt;
                if (dn_cnt != '0 && dn_cnt <= WARN_SEC)
                    beep = BEEP_WARN;
                if (dn_cnt == '0)
                begin
                    beep = BEEP_PHASE;
                    if (work_reg)
                    begin
                        work_next = 1'b0;
                        sec_next  = cfg.rest_seconds;
                        if (rnd_reg <= 7'd1)
                        begin
                            done_next = 1'b1;
                            beep      = BEEP_FINISH;
                        end
                    end
                    else
                    begin
                        work_next = 1'b1;
                        sec_next  = cfg.work_seconds;
                        rnd_next  = rnd_dec;
                    end
                end
            end
        end
    end

    assign result.seconds_shown = sec_next;
    assign result.round_shown   = rnd_next;
    assign result.in_work       = work_next;
    assign result.done_res      = done_next;
    assign result.beep_count    = beep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg  <= '0;
            rnd_reg  <= '0;
            work_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (step)
        begin
            sec_reg  <= sec_next;
            rnd_reg  <= rnd_next;
            work_reg <= work_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== hw/rtl/work_rest_interval_timer.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+------------------------------------------
// item      | item_valid / item_ready      | item   (op, hold)
// result    | result_valid / result_ready  | result (seconds, round, phase, done, beeps)
// config    | psel/penable/pwrite, pready  | paddr, pwdata, prdata (4 regs at 4*i)
//
// One item per cycle sustained while result_ready holds. An item lands in the
// input register on its transfer, is evaluated against the timer state when
// it advances, and its result is captured in the output register at the same
// edge that updates the state, which raises result_valid.
// Reset clears both valid flags, the counters and the done flag; the phase
// resets to work and the registers to their defaults.
// A stalled result holds the output register; the input register still
// takes one more item, and item_ready drops only while both are full.
module work_rest_interval_timer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  writ_pkg::writ_item_t        item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output writ_pkg::writ_result_t      result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [writ_pkg::ApbAw-1:0]  paddr,
    input  logic [writ_pkg::ApbDw-1:0]  pwdata,
    output logic [writ_pkg::ApbDw-1:0]  prdata,
    output logic                        pready
);
    import writ_pkg::*;

    writ_cfg_t    cfg;
    writ_item_t   item_reg;
    logic         item_vld_reg;
    logic         item_vld_next;
    writ_result_t res_reg;
    writ_result_t core_res;
    logic         res_vld_reg;
    logic         res_vld_next;
    logic         advance;

    // Move the held item into the result stage when that stage is free
    // or being drained in this cycle.
    assign advance    = item_vld_reg && (!res_vld_reg || result_ready);
    assign item_ready = !item_vld_reg || advance;

    assign item_vld_next = (item_valid && item_ready) ? 1'b1 :
                           (advance ? 1'b0 : item_vld_reg);
    assign res_vld_next  = advance ? 1'b1 :
                           (result_ready ? 1'b0 : res_vld_reg);

    writ_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    writ_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_res)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (advance)
            res_reg <= core_res;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule
